// ----- sv/tba_pkg.sv -----
// shared constants, register codes and helper functions of the time bucket aggregator
package tba_pkg;

    // default storage depth of one bucket
    localparam int MAX_GROUP_DEF = 64;

    // fixed field widths
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 32;
    localparam int OUT_VAL_W = 40;
    localparam int CNT_OUT_W = 7;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd1000;

    // aggregate mode codes, unused codes act as mean
    localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUM    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAX    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGGREGATE_MODE  = 2'd1;

    // clamp a wide signed value to the result value range
    function automatic logic signed [OUT_VAL_W-1:0] sat_value(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd549755813887;
        lo = -64'sd549755813888;
        if (x > hi) begin
            return hi[OUT_VAL_W-1:0];
        end else if (x < lo) begin
            return lo[OUT_VAL_W-1:0];
        end
        return x[OUT_VAL_W-1:0];
    endfunction

    // clamp a sample count to the count field
    function automatic logic [CNT_OUT_W-1:0] count_out(input logic [15:0] c);
        if (c > 16'd127) begin
            return 7'd127;
        end
        return c[CNT_OUT_W-1:0];
    endfunction

endpackage

// ----- sv/tba_div.sv -----
// iterative restoring divider for the bucket mean, one quotient bit per cycle
module tba_div import tba_pkg::*; #(
    parameter int SW = 39,
    parameter int CW = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [SW-1:0] dividend,
    input  logic [CW-1:0]        divisor,
    output logic                 done,
    output logic signed [SW-1:0] quotient
);

    localparam int STEP_W = $clog2(SW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     rem_reg;
    logic [SW-1:0]     q_reg;
    logic [CW-1:0]     div_reg;

    logic [CW:0]       trial;
    logic              fits;
    logic [SW-1:0]     mag;

    // one restoring step
    assign trial = {rem_reg, q_reg[SW-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign mag   = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[SW-1];
                q_reg    <= mag;
                rem_reg  <= '0;
                div_reg  <= divisor;
                step_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? CW'(trial - {1'b0, div_reg}) : trial[CW-1:0];
                q_reg    <= {q_reg[SW-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // truncation toward zero: apply the dividend sign to the magnitude quotient
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ----- sv/time_bucket_aggregator.sv -----
// Each sample is accepted, then written once into the sample memories.
// Closing a bucket passes through the close state for sum, min or max, the serial divider for mean,
// and a rank search over the value memory for median (one read a cycle).
// A result then waits in the output register until taken; the next sample may enter meanwhile.
// Reset is synchronous, active low; the sample memories need no clearing.
module time_bucket_aggregator import tba_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wr_data,
    // samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // sample_time[31:0], sample_value[63:32]
    input  logic                  s_tlast,   // series_end
    // buckets
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // bucket_time[31:0], bucket_value[71:32],
                                             // bucket_count[78:72], bucket_overflow[79]
    output logic                  m_tlast    // last_bucket
);

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int SW = VAL_W + 1 + AW;

    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_CLOSE, S_DIV, S_CAND, S_CANDW, S_SCAN, S_DRAIN,
        S_EVAL, S_MED, S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [TIME_W-1:0]       interval_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [TIME_W-1:0]       in_time_reg;
    logic signed [VAL_W-1:0] in_value_reg;
    logic                    in_end_reg;
    logic [CW-1:0]           size_reg;
    logic signed [SW-1:0]    sum_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic [TIME_W:0]         boundary_reg;
    logic                    active_reg;
    logic                    close_ovf_reg;
    logic                    close_last_reg;
    logic signed [OUT_VAL_W-1:0] val_reg;
    // median search
    logic [CW-1:0]           i_reg;
    logic [CW-1:0]           j_reg;
    logic [CW-1:0]           less_reg;
    logic [CW-1:0]           leq_reg;
    logic                    pipe_vld_reg;
    logic signed [VAL_W-1:0] cand_reg;
    logic signed [VAL_W-1:0] med_a_reg;
    logic signed [VAL_W-1:0] med_b_reg;
    // output register
    logic                    m_tvalid_reg;
    logic [79:0]             m_tdata_reg;
    logic                    m_tlast_reg;

    // sample memories
    logic signed [VAL_W-1:0] vals_mem [MAX_GROUP];
    logic [TIME_W-1:0]       times_mem [MAX_GROUP];
    logic signed [VAL_W-1:0] vals_q;
    logic [TIME_W-1:0]       times_q;
    logic [AW-1:0]           vals_raddr;
    logic [AW-1:0]           times_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;

    logic                    accept;
    logic                    opening;
    logic                    hit_boundary;
    logic                    hit_depth;
    logic                    out_free;
    logic [CW-1:0]           k_hi;
    logic [CW-1:0]           k_lo;
    logic                    div_start;
    logic                    div_done;
    logic signed [SW-1:0]    div_q;
    logic signed [VAL_W:0]   med_pair;
    logic [TIME_W-1:0]       s_time;
    logic signed [VAL_W-1:0] s_value;

    assign s_time  = s_tdata[31:0];
    assign s_value = $signed(s_tdata[63:32]);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // close tests against the open bucket
    assign hit_boundary = active_reg && (size_reg != '0) &&
                          ({1'b0, s_time} >= boundary_reg);
    assign hit_depth    = active_reg && (size_reg != '0) && !hit_boundary &&
                          (size_reg >= CW'(MAX_GROUP));
    assign opening      = !active_reg || (size_reg == '0);

    // memory write and read addresses
    assign mem_we      = (state_reg == S_APPEND);
    assign mem_waddr   = opening ? '0 : size_reg[AW-1:0];
    assign times_raddr = AW'(size_reg >> 1);
    assign vals_raddr  = (state_reg == S_SCAN) ? j_reg[AW-1:0] : i_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vals_mem[mem_waddr]  <= in_value_reg;
            times_mem[mem_waddr] <= in_time_reg;
        end
        vals_q  <= vals_mem[vals_raddr];
        times_q <= times_mem[times_raddr];
    end

    // ranks wanted for the median
    assign k_hi     = size_reg >> 1;
    assign k_lo     = size_reg[0] ? k_hi : k_hi - 1'b1;
    assign med_pair = (VAL_W+1)'(med_a_reg) + (VAL_W+1)'(med_b_reg);

    assign div_start = (state_reg == S_CLOSE) && (mode_reg != MODE_SUM) &&
                       (mode_reg != MODE_MIN) && (mode_reg != MODE_MAX) &&
                       (mode_reg != MODE_MEDIAN);

    tba_div #(.SW(SW), .CW(CW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (size_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer, bucket state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            interval_reg   <= INTERVAL_RESET;
            mode_reg       <= MODE_MEAN;
            size_reg       <= '0;
            active_reg     <= 1'b0;
            pipe_vld_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            close_ovf_reg  <= 1'b0;
            close_last_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_BUCKET_INTERVAL) begin
                    interval_reg <= cfg_wr_data[TIME_W-1:0];
                end else if (cfg_wr_index == REG_AGGREGATE_MODE) begin
                    mode_reg <= cfg_wr_data[MODE_W-1:0];
                end
            end

            // result taken, the emit state refills the register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            // rank counting in the cycle after each value read
            pipe_vld_reg <= (state_reg == S_SCAN);
            if (pipe_vld_reg) begin
                less_reg <= less_reg + CW'(vals_q < cand_reg);
                leq_reg  <= leq_reg + CW'(vals_q <= cand_reg);
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        in_time_reg  <= s_time;
                        in_value_reg <= s_value;
                        in_end_reg   <= s_tlast;
                        if (hit_boundary || hit_depth) begin
                            close_ovf_reg  <= hit_depth;
                            close_last_reg <= 1'b0;
                            state_reg      <= S_CLOSE;
                        end else begin
                            state_reg <= S_APPEND;
                        end
                    end
                end
                S_APPEND: begin
                    if (opening) begin
                        size_reg     <= CW'(1);
                        sum_reg      <= SW'(in_value_reg);
                        min_reg      <= in_value_reg;
                        max_reg      <= in_value_reg;
                        boundary_reg <= {1'b0, in_time_reg} + {1'b0, interval_reg};
                        active_reg   <= 1'b1;
                    end else begin
                        size_reg <= size_reg + 1'b1;
                        sum_reg  <= sum_reg + SW'(in_value_reg);
                        if (in_value_reg < min_reg) begin
                            min_reg <= in_value_reg;
                        end
                        if (in_value_reg > max_reg) begin
                            max_reg <= in_value_reg;
                        end
                    end
                    if (in_end_reg) begin
                        close_ovf_reg  <= 1'b0;
                        close_last_reg <= 1'b1;
                        state_reg      <= S_CLOSE;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CLOSE: begin
                    if (mode_reg == MODE_SUM) begin
                        val_reg   <= sat_value(64'(sum_reg));
                        state_reg <= S_EMIT;
                    end else if (mode_reg == MODE_MIN) begin
                        val_reg   <= OUT_VAL_W'(min_reg);
                        state_reg <= S_EMIT;
                    end else if (mode_reg == MODE_MAX) begin
                        val_reg   <= OUT_VAL_W'(max_reg);
                        state_reg <= S_EMIT;
                    end else if (mode_reg == MODE_MEDIAN) begin
                        i_reg     <= '0;
                        state_reg <= S_CAND;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        val_reg   <= sat_value(64'(div_q));
                        state_reg <= S_EMIT;
                    end
                end
                S_CAND: begin
                    state_reg <= S_CANDW;
                end
                S_CANDW: begin
                    cand_reg  <= vals_q;
                    j_reg     <= '0;
                    less_reg  <= '0;
                    leq_reg   <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == size_reg - 1'b1) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    // candidate holds rank k when less <= k < leq
                    if (less_reg <= k_lo && k_lo < leq_reg) begin
                        med_a_reg <= cand_reg;
                    end
                    if (less_reg <= k_hi && k_hi < leq_reg) begin
                        med_b_reg <= cand_reg;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == size_reg - 1'b1) begin
                        state_reg <= S_MED;
                    end else begin
                        state_reg <= S_CAND;
                    end
                end
                S_MED: begin
                    // floor average of the two middle values
                    val_reg   <= OUT_VAL_W'(med_pair >>> 1);
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {close_ovf_reg, count_out(16'(size_reg)),
                                         val_reg, times_q};
                        m_tlast_reg  <= close_last_reg;
                        size_reg     <= '0;
                        if (close_last_reg) begin
                            active_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end else begin
                            state_reg <= S_APPEND;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- sv/tba_checker.sv -----
// port-level checks of the time bucket aggregator and their binding
module tba_checker import tba_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    localparam logic [CNT_OUT_W-1:0] FULL_COUNT =
        (MAX_GROUP > 127) ? 7'd127 : CNT_OUT_W'(MAX_GROUP);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // every bucket holds at least one sample
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[78:72] != '0)
        else $error("empty bucket emitted");

    // an early close only happens with full storage
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[79] |-> m_tdata[78:72] == FULL_COUNT)
        else $error("overflow flag on a bucket that is not full");

    // a sample transaction is followed by its memory write cycle
    a_write_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken back to back");

endmodule

bind time_bucket_aggregator tba_checker #(.MAX_GROUP(MAX_GROUP)) u_tba_checker (.*);
